@@ design/bcld_pkg.sv @@
// Shared types and constants for the button chord long-press detector.
// No dependencies; used by the core and its checker.
package bcld_pkg;

    localparam int BTN_W        = 2;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 32;
    localparam int BUTTON_COUNT = 2;

    // Buttons beyond BUTTON_COUNT are ignored.
    localparam logic [BTN_W-1:0] BTN_MASK =
        (BUTTON_COUNT >= BTN_W) ? {BTN_W{1'b1}} : BTN_W'((1 << BUTTON_COUNT) - 1);

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd10000;
    localparam logic [TIME_W-1:0] LONG_RESET     = 32'd1000000;

    // Register byte address bit that selects the register.
    localparam int ADDR_W = 3;
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_LONG     = 1'b1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [CNT_W-1:0] dropped_count;
        logic [BTN_W-1:0] stable_buttons;
        logic             long_press_pulse;
        logic [BTN_W-1:0] chord_mask;
        logic             press_kind;
        logic             event_valid;
    } result_t;

endpackage

@@ design/button_chord_long_press_detector_core.sv @@
// Button chord long-press detector: debounce, episode machine, one-slot mailbox.
// Depends on bcld_pkg for widths, codes and the result record.
//
//  channel   | ports                       | payload (lsb first)
//  ----------+-----------------------------+------------------------------------------
//  input     | s_tvalid s_tready s_tdata   | tdata: raw_buttons[1:0], now_us[33:2]
//            | s_tuser                     | tuser: mode (0 tick, 1 take)
//  result    | m_tvalid m_tready m_tdata   | event_valid, press_kind, chord_mask,
//            |                             | long_press_pulse, stable_buttons,
//            |                             | dropped_count
//  config    | psel penable pwrite paddr   | 0x0 debounce_window_us, 0x4 long_press_us
//
// One item per clock while s_tready is high; each result is registered in the output or skid register.
// The state update is one pass of logic between the state registers, set by the
// two 32-bit timestamp subtract-compares.
// Reset (aresetn low, synchronous) clears all state, mailbox and counters, and loads
// the default windows. A stalled result moves into a one-item skid register, so
// s_tready falls only while both the output and the skid register are occupied.
module button_chord_long_press_detector_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcld_pkg::S_TDATA_W-1:0] s_tdata,  // raw_buttons[1:0], now_us[33:2], 0
    input  logic                           s_tuser,  // mode
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_valid[0], press_kind[1], chord_mask[3:2], long_press_pulse[4],
    // stable_buttons[6:5], dropped_count[38:7], 0
    output logic [bcld_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bcld_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HOLD = 2'd1;
    localparam logic [1:0] ST_LOCK = 2'd2;

    localparam int BW = bcld_pkg::BTN_W;
    localparam int TW = bcld_pkg::TIME_W;
    localparam int CW = bcld_pkg::CNT_W;

    // configuration registers
    logic [TW-1:0] debounce_reg, long_reg;

    // block state
    logic [BW-1:0] last_raw_reg, last_raw_next;
    logic [TW-1:0] change_time_reg, change_time_next;
    logic [BW-1:0] stable_reg, stable_next;
    logic [1:0]    ep_reg, ep_next;
    logic [BW-1:0] chord_reg, chord_next;
    logic [TW-1:0] hold_time_reg, hold_time_next;
    logic          mb_full_reg, mb_full_next;
    logic          mb_kind_reg, mb_kind_next;
    logic [BW-1:0] mb_chord_reg, mb_chord_next;
    logic [CW-1:0] drop_reg, drop_next;

    // output and skid stages
    bcld_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic          accept;
    logic          mode;
    logic [BW-1:0] raw;
    logic [TW-1:0] now;
    logic          put;
    logic          put_kind;
    logic          pulse;
    logic [TW-1:0] raw_age, hold_age;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == bcld_pkg::REG_LONG) ? long_reg : debounce_reg;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = bcld_pkg::M_TDATA_W'(out_reg);

    assign mode = s_tuser;
    assign raw  = s_tdata[BW-1:0] & bcld_pkg::BTN_MASK;
    assign now  = s_tdata[BW+TW-1:BW];

    assign raw_age  = now - change_time_reg;
    assign hold_age = now - hold_time_reg;

    // debounce filter: a raw change restarts the window
    always_comb begin
        last_raw_next    = last_raw_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        if (raw != last_raw_reg) begin
            last_raw_next    = raw;
            change_time_next = now;
        end else if (raw != stable_reg && raw_age >= debounce_reg) begin
            stable_next = raw;
        end
    end

    // episode machine, driven by the freshly debounced value
    always_comb begin
        ep_next        = ep_reg;
        chord_next     = chord_reg;
        hold_time_next = hold_time_reg;
        put            = 1'b0;
        put_kind       = bcld_pkg::KIND_SHORT;
        pulse          = 1'b0;
        case (ep_reg)
            ST_IDLE: begin
                if (stable_next != '0) begin
                    chord_next     = stable_next;
                    hold_time_next = now;
                    ep_next        = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (stable_next == '0) begin
                    put        = 1'b1;
                    ep_next    = ST_IDLE;
                    chord_next = '0;
                end else if ((stable_next | chord_reg) != chord_reg) begin
                    // widening the chord restarts the hold timer
                    chord_next     = chord_reg | stable_next;
                    hold_time_next = now;
                end else if (hold_age >= long_reg) begin
                    put      = 1'b1;
                    put_kind = bcld_pkg::KIND_LONG;
                    pulse    = 1'b1;
                    ep_next  = ST_LOCK;
                end
            end
            default: begin
                // locked, and the unused code: wait for full release
                if (stable_next == '0) begin
                    ep_next    = ST_IDLE;
                    chord_next = '0;
                end
            end
        endcase
    end

    // mailbox and result
    always_comb begin
        mb_full_next  = mb_full_reg;
        mb_kind_next  = mb_kind_reg;
        mb_chord_next = mb_chord_reg;
        drop_next     = drop_reg;
        res           = '0;
        if (mode == bcld_pkg::MODE_TAKE) begin
            res.event_valid = mb_full_reg;
            res.press_kind  = mb_full_reg & mb_kind_reg;
            res.chord_mask  = mb_full_reg ? mb_chord_reg : '0;
            mb_full_next    = 1'b0;
            mb_kind_next    = 1'b0;
            mb_chord_next   = '0;
        end else begin
            if (put) begin
                if (mb_full_reg) begin
                    drop_next = drop_reg + CW'(1);
                end else begin
                    mb_full_next  = 1'b1;
                    mb_kind_next  = put_kind;
                    mb_chord_next = chord_reg;
                end
            end
            res.event_valid      = mb_full_next;
            res.press_kind       = mb_full_next & mb_kind_next;
            res.chord_mask       = mb_full_next ? mb_chord_next : '0;
            res.long_press_pulse = pulse;
        end
        res.stable_buttons = (mode == bcld_pkg::MODE_TAKE) ? stable_reg : stable_next;
        res.dropped_count  = drop_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bcld_pkg::DEBOUNCE_RESET;
            long_reg     <= bcld_pkg::LONG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == bcld_pkg::REG_LONG) begin
                long_reg <= pwdata;
            end else begin
                debounce_reg <= pwdata;
            end
        end
    end

    // state update on every accepted item; a take leaves debounce and episode alone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg    <= '0;
            change_time_reg <= '0;
            stable_reg      <= '0;
            ep_reg          <= ST_IDLE;
            chord_reg       <= '0;
            hold_time_reg   <= '0;
            mb_full_reg     <= 1'b0;
            mb_kind_reg     <= 1'b0;
            mb_chord_reg    <= '0;
            drop_reg        <= '0;
        end else if (accept) begin
            if (mode == bcld_pkg::MODE_TICK) begin
                last_raw_reg    <= last_raw_next;
                change_time_reg <= change_time_next;
                stable_reg      <= stable_next;
                ep_reg          <= ep_next;
                chord_reg       <= chord_next;
                hold_time_reg   <= hold_time_next;
            end
            mb_full_reg  <= mb_full_next;
            mb_kind_reg  <= mb_kind_next;
            mb_chord_reg <= mb_chord_next;
            drop_reg     <= drop_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

endmodule

@@ design/bcld_checker.sv @@
// Port-level checks for the button chord long-press detector core.
// Depends on bcld_pkg; bound to the core at the end of this file.
module bcld_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bcld_pkg::M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // input backpressure only while a result is waiting
    a_ready_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a long-press tick always leaves the mailbox full
    a_pulse_has_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[0])
        else $error("long press pulse without mailbox event");

    // an empty mailbox reports no kind and no chord
    a_empty_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> !m_tdata[1] && m_tdata[3:2] == 2'b00)
        else $error("empty mailbox reports event content");

endmodule

bind button_chord_long_press_detector_core bcld_checker u_bcld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/button_chord_long_press_detector_core_tb.sv @@
// Self-checking testbench for the button chord long-press detector core.
// Depends on bcld_pkg and button_chord_long_press_detector_core; drives stream
// and APB ports and checks every result item against a cycle-free predictor.
module button_chord_long_press_detector_core_tb;

    // Cycles with no handshake at all before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to let the pipeline settle once the last expected item is back.
    localparam int SETTLE      = 4;

    localparam int BTN_W  = bcld_pkg::BTN_W;
    localparam int TIME_W = bcld_pkg::TIME_W;
    localparam int CNT_W  = bcld_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOLD,
        ST_LOCK
    } episode_t;

    // Predicts the detector item by item and holds the results still owed.
    class chord_scoreboard;
        logic [TIME_W-1:0]   debounce_us = bcld_pkg::DEBOUNCE_RESET;
        logic [TIME_W-1:0]   long_us     = bcld_pkg::LONG_RESET;
        logic [BTN_W-1:0]    last_raw    = '0;
        logic [BTN_W-1:0]    stable      = '0;
        logic [BTN_W-1:0]    chord       = '0;
        logic [TIME_W-1:0]   raw_since   = '0;
        logic [TIME_W-1:0]   hold_since  = '0;
        episode_t            episode     = ST_IDLE;
        logic                mbox_full   = 1'b0;
        logic                mbox_kind   = bcld_pkg::KIND_SHORT;
        logic [BTN_W-1:0]    mbox_chord  = '0;
        logic [CNT_W-1:0]    drops       = '0;
        bcld_pkg::result_t   owed_q[$];
        int                  errors      = 0;

        // One-slot mailbox: a second event is lost and counted.
        function void post_event(logic kind, logic [BTN_W-1:0] bits);
            if (mbox_full) begin
                drops = drops + 1'b1;
            end else begin
                mbox_kind  = kind;
                mbox_chord = bits;
                mbox_full  = 1'b1;
            end
        endfunction

        function void note_item(logic mode, logic [BTN_W-1:0] raw_in, logic [TIME_W-1:0] now);
            logic [BTN_W-1:0]  raw;
            logic              pulse;
            bcld_pkg::result_t r;
            raw   = raw_in & bcld_pkg::BTN_MASK;
            pulse = 1'b0;
            if (mode == bcld_pkg::MODE_TAKE) begin
                r.event_valid = mbox_full;
                r.press_kind  = mbox_full ? mbox_kind : bcld_pkg::KIND_SHORT;
                r.chord_mask  = mbox_full ? mbox_chord : '0;
                mbox_full  = 1'b0;
                mbox_kind  = bcld_pkg::KIND_SHORT;
                mbox_chord = '0;
            end else begin
                // Shared debounce: a change restarts the window.
                if (raw != last_raw) begin
                    last_raw  = raw;
                    raw_since = now;
                end else if (raw != stable && TIME_W'(now - raw_since) >= debounce_us) begin
                    stable = raw;
                end
                case (episode)
                    ST_IDLE: begin
                        if (stable != '0) begin
                            chord      = stable;
                            hold_since = now;
                            episode    = ST_HOLD;
                        end
                    end
                    ST_HOLD: begin
                        if (stable == '0) begin
                            post_event(bcld_pkg::KIND_SHORT, chord);
                            episode = ST_IDLE;
                            chord   = '0;
                        end else if ((stable | chord) != chord) begin
                            chord      = chord | stable;
                            hold_since = now;
                        end else if (TIME_W'(now - hold_since) >= long_us) begin
                            post_event(bcld_pkg::KIND_LONG, chord);
                            episode = ST_LOCK;
                            pulse   = 1'b1;
                        end
                    end
                    default: begin
                        if (stable == '0) begin
                            episode = ST_IDLE;
                            chord   = '0;
                        end
                    end
                endcase
                r.event_valid = mbox_full;
                r.press_kind  = mbox_full ? mbox_kind : bcld_pkg::KIND_SHORT;
                r.chord_mask  = mbox_full ? mbox_chord : '0;
            end
            r.long_press_pulse = pulse;
            r.stable_buttons   = stable;
            r.dropped_count    = drops;
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(bcld_pkg::result_t got);
            bcld_pkg::result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %0h", $time, got);
                return;
            end
            want = owed_q.pop_front();
            compare_field("event_valid",      want.event_valid,      got.event_valid);
            compare_field("press_kind",       want.press_kind,       got.press_kind);
            compare_field("chord_mask",       want.chord_mask,       got.chord_mask);
            compare_field("long_press_pulse", want.long_press_pulse, got.long_press_pulse);
            compare_field("stable_buttons",   want.stable_buttons,   got.stable_buttons);
            compare_field("dropped_count",    want.dropped_count,    got.dropped_count);
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bcld_pkg::S_TDATA_W-1:0]  s_tdata;   // raw_buttons[1:0], now_us[33:2], 0
    logic                            s_tuser;   // mode
    logic                            m_tvalid;
    logic                            m_tready;
    // event_valid[0], press_kind[1], chord_mask[3:2], long_press_pulse[4],
    // stable_buttons[6:5], dropped_count[38:7], 0
    logic [bcld_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bcld_pkg::ADDR_W-1:0]     paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    chord_scoreboard board = new();
    int send_calm = 0;
    int recv_calm = 0;
    int quiet = 0;

    button_chord_long_press_detector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Draw a random wait, with occasional stretches of back-to-back
    // traffic so that full-rate behavior is exercised as well.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        return $urandom_range(0, 6);
    endfunction

    // Offer one item and hold it until the core takes it. Keep tvalid high
    // across back-to-back items so it never sees a drop and raise in one step.
    task automatic send_item(logic mode, logic [BTN_W-1:0] raw, logic [TIME_W-1:0] now);
        int gap;
        gap = pick_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= bcld_pkg::S_TDATA_W'({now, raw});
        do @(posedge aclk); while (!s_tready);
        board.note_item(mode, raw, now);
    endtask

    // Hold off the sender until every owed result is back, then let the
    // core settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register lands when pready is seen.
    // End with the bus idle.
    task automatic apb_write(logic sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == bcld_pkg::REG_DEBOUNCE)
            board.debounce_us = value;
        else
            board.long_us = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Change both windows, only with nothing in flight.
    task automatic reconfigure(logic [TIME_W-1:0] debounce, logic [TIME_W-1:0] hold);
        drain();
        apb_write(bcld_pkg::REG_DEBOUNCE, debounce);
        apb_write(bcld_pkg::REG_LONG, hold);
    endtask

    // Random phase: mostly press/widen/release scripts held for a number of
    // ticks, with bounces, take requests, big timestamp jumps and pauses.
    task automatic run_phase(int count, int step_max, logic [TIME_W-1:0] start_at);
        logic [BTN_W-1:0]  held;
        logic [BTN_W-1:0]  raw;
        logic [TIME_W-1:0] now;
        int                hold_left;
        now       = start_at;
        held      = '0;
        hold_left = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0)
                drain();
            if ($urandom_range(0, 99) < 12) begin
                // take: the button and time fields are don't-care, so randomize them
                send_item(bcld_pkg::MODE_TAKE, BTN_W'($urandom_range(0, 3)), $urandom());
            end else begin
                if (hold_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            held = '0;
                        end
                        1: begin
                            held = held | BTN_W'($urandom_range(1, 3));
                        end
                        default: begin
                            held = BTN_W'($urandom_range(0, 3));
                        end
                    endcase
                    hold_left = $urandom_range(1, 30);
                end
                hold_left--;
                raw = ($urandom_range(0, 99) < 8) ? BTN_W'($urandom_range(0, 3)) : held;
                if ($urandom_range(0, 49) == 0)
                    now = now + $urandom();
                else
                    now = now + TIME_W'($urandom_range(0, step_max));
                send_item(bcld_pkg::MODE_TICK, raw, now);
            end
        end
    endtask

    // Check every result item as it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(
                bcld_pkg::result_t'(m_tdata[$bits(bcld_pkg::result_t)-1:0]));
    end

    // Watchdog: end the run if neither side nor the config port moves.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Result side: stall a random number of cycles before each item.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = pick_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [TIME_W-1:0] rand_debounce;
        logic [TIME_W-1:0] rand_hold;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = bcld_pkg::MODE_TICK;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: short windows, timestamps straddling the 32-bit wrap.
        reconfigure(32'd2, 32'd10);
        send_item(bcld_pkg::MODE_TAKE, 2'b11, 32'hFFFF_FFFF);  // take on an empty mailbox
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'hFFFF_FFF0);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'hFFFF_FFF2);  // button 0 stable, opens
        send_item(bcld_pkg::MODE_TICK, 2'b11, 32'hFFFF_FFF3);
        send_item(bcld_pkg::MODE_TICK, 2'b11, 32'hFFFF_FFF5);  // chord widens, restart
        send_item(bcld_pkg::MODE_TICK, 2'b11, 32'hFFFF_FFF6);
        send_item(bcld_pkg::MODE_TICK, 2'b11, 32'h0000_0003);  // long press across wrap
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0004);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0006);  // locked episode released
        send_item(bcld_pkg::MODE_TICK, 2'b10, 32'h0000_0007);
        send_item(bcld_pkg::MODE_TICK, 2'b10, 32'h0000_0009);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_000A);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_000C);  // short press lost
        send_item(bcld_pkg::MODE_TAKE, 2'b00, 32'h0000_0000);  // returns the long press
        send_item(bcld_pkg::MODE_TAKE, 2'b01, 32'h5555_5555);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'h0000_0014);  // one-sample bounce
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0015);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0030);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'h0000_0040);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'h0000_0042);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0043);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0045);  // short press posted
        send_item(bcld_pkg::MODE_TAKE, 2'b10, 32'hAAAA_AAAA);

        // Zero windows: stable on the repeat sample, long on the next quiet tick.
        reconfigure(32'd0, 32'd0);
        send_item(bcld_pkg::MODE_TICK, 2'b10, 32'h0000_0100);
        send_item(bcld_pkg::MODE_TICK, 2'b10, 32'h0000_0100);
        send_item(bcld_pkg::MODE_TICK, 2'b10, 32'h0000_0100);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0101);
        send_item(bcld_pkg::MODE_TICK, 2'b00, 32'h0000_0101);
        run_phase(200, 2, $urandom());

        // Power-on windows with microsecond-scale steps.
        reconfigure(bcld_pkg::DEBOUNCE_RESET, bcld_pkg::LONG_RESET);
        run_phase(250, 60000, 32'hFFF0_0000);

        reconfigure(32'd5, 32'd40);
        run_phase(250, 6, 32'hFFFF_FF00);

        // Largest windows: only a difference of all ones passes.
        reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'h0000_0005);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'h0000_0004);
        send_item(bcld_pkg::MODE_TICK, 2'b01, 32'h0000_0003);
        run_phase(150, 3, $urandom());

        repeat (3) begin
            rand_debounce = $urandom_range(0, 20);
            rand_hold     = $urandom_range(0, 120);
            reconfigure(rand_debounce, rand_hold);
            run_phase(150, (rand_debounce + rand_hold) / 15 + 2, $urandom());
        end

        drain();
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
